// ===== rtl/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dnle_pkg;

    localparam int unsigned LEN_W  = 6;
    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_DOT = 8'd46;
    localparam logic [CHAR_W-1:0] CH_END = 8'd0;

    // One label flush, handed from the front end to the playback engine.
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             closing;
    } flush_cmd_t;

    // Playback engine has finished with a buffer bank.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LEN,
        B_BYTE,
        B_TERM
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/dns_name_label_encoder.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Turns a dotted host name, one character per transfer, into DNS wire form.
//
//   Channel  Dir  Payload                                    Last / user
//   s_axis   in   tdata[7:0] name_char                       -
//   m_axis   out  tdata[7:0] out_byte                        tlast last_of_run,
//                                                            tuser name_done,
//                                                            label_overflow
//
// Playback of a flush of an n-byte label gives its length byte and its n
// bytes, and a zero byte at the end of a name, after an idle state that
// picks up the flush; the single output register sets that pace. Two buffer
// banks let the next label fill while one is replayed; s_axis stalls only
// when both banks wait for playback. Reset clears control state only; the
// buffer memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_label_encoder #(
    parameter int unsigned LABEL_MAX = 62
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] name_char
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // last_of_run
    output logic [1:0] m_axis_tuser    // [0] name_done, [1] label_overflow
);

    localparam int unsigned AW = (2 * LABEL_MAX > 1) ? $clog2(2 * LABEL_MAX) : 1;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [dnle_pkg::CHAR_W-1:0]  wr_data;
    logic                         push;
    logic                         q_not_full;
    logic                         q_not_empty;
    logic                         pop;
    dnle_pkg::flush_cmd_t         push_cmd;
    dnle_pkg::flush_cmd_t         head_cmd;
    dnle_pkg::bank_rel_t          rel;

    dnle_front #(
        .LABEL_MAX (LABEL_MAX),
        .AW        (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .cmd_valid (push),
        .cmd_ready (q_not_full),
        .cmd       (push_cmd),
        .rel       (rel)
    );

    dnle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .not_full  (q_not_full),
        .push_data (push_cmd),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (head_cmd)
    );

    dnle_back #(
        .LABEL_MAX (LABEL_MAX),
        .AW        (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .cmd_valid (q_not_empty),
        .cmd_pop   (pop),
        .cmd       (head_cmd),
        .rel       (rel),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_done  (m_axis_tuser[0]),
        .out_ovf   (m_axis_tuser[1])
    );

endmodule

`default_nettype wire

// ===== rtl/dnle_front.sv =====
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, writes label bytes into the current buffer bank
// and issues a flush command on a dot or the end of the name.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_front #(
    parameter int unsigned LABEL_MAX = 62,
    parameter int unsigned AW        = 7
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [dnle_pkg::CHAR_W-1:0]    in_char,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [dnle_pkg::CHAR_W-1:0]    wr_data,
    output logic                           cmd_valid,
    input  wire                            cmd_ready,
    output dnle_pkg::flush_cmd_t           cmd,
    input  dnle_pkg::bank_rel_t            rel
);

    logic                        bank_reg, bank_next;
    logic [dnle_pkg::LEN_W-1:0]  count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [1:0]                  busy_reg, busy_next;
    logic                        accept;
    logic                        is_flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            bank_reg  <= bank_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
        end
    end

    // A bank is held from its flush until playback releases it.
    assign in_ready = !busy_reg[bank_reg] && cmd_ready;
    assign accept   = in_valid && in_ready;
    assign is_flush = (in_char == dnle_pkg::CH_DOT) || (in_char == dnle_pkg::CH_END);

    assign wr_data = in_char;
    assign wr_addr = AW'((bank_reg ? LABEL_MAX : 0) + count_reg);

    assign cmd.bank    = bank_reg;
    assign cmd.len     = count_reg;
    assign cmd.ovf     = ovf_reg;
    assign cmd.closing = (in_char == dnle_pkg::CH_END);

    always_comb
    begin
        bank_next  = bank_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        wr_en      = 1'b0;
        cmd_valid  = 1'b0;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (is_flush)
            begin
                cmd_valid           = 1'b1;
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
                count_next          = '0;
                ovf_next            = 1'b0;
            end
            else if (count_reg < dnle_pkg::LEN_W'(LABEL_MAX))
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dnle_queue.sv =====
// ----------------------------------------------------------------------------
// dnle_queue
// Two-entry queue of flush commands between the front end and playback.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    output logic                  not_full,
    input  dnle_pkg::flush_cmd_t  push_data,
    input  wire                   pop,
    output logic                  not_empty,
    output dnle_pkg::flush_cmd_t  pop_data
);

    dnle_pkg::flush_cmd_t  entry_reg [2];
    logic                  wp_reg, wp_next;
    logic                  rp_reg, rp_next;
    logic [1:0]            fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign not_full  = (fill_reg != 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rp_reg];

    always_comb
    begin
        wp_next   = wp_reg ^ do_push;
        rp_next   = rp_reg ^ do_pop;
        fill_next = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wp_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dnle_back.sv =====
// ----------------------------------------------------------------------------
// dnle_back
// Playback engine: holds the two label buffer banks and replays each flush
// as a length byte, the label bytes and, at the end of a name, a zero byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_back #(
    parameter int unsigned LABEL_MAX = 62,
    parameter int unsigned AW        = 7
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          wr_en,
    input  wire  [AW-1:0]                wr_addr,
    input  wire  [dnle_pkg::CHAR_W-1:0]  wr_data,
    input  wire                          cmd_valid,
    output logic                         cmd_pop,
    input  dnle_pkg::flush_cmd_t         cmd,
    output dnle_pkg::bank_rel_t          rel,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [dnle_pkg::CHAR_W-1:0]  out_byte,
    output logic                         out_last,
    output logic                         out_done,
    output logic                         out_ovf
);

    localparam int unsigned DEPTH = 2 * LABEL_MAX;
    localparam int unsigned RW    = $clog2(DEPTH + 1);

    logic [dnle_pkg::CHAR_W-1:0]  mem [DEPTH];
    logic [dnle_pkg::CHAR_W-1:0]  rd_data_reg;
    logic [RW-1:0]                rd_addr;

    dnle_pkg::back_state_t        state_reg, state_next;
    dnle_pkg::flush_cmd_t         cmd_reg, cmd_next;
    logic [dnle_pkg::LEN_W-1:0]   idx_reg, idx_next;

    logic                         ov_reg, ov_next;
    logic [dnle_pkg::CHAR_W-1:0]  ob_reg, ob_next;
    logic                         ol_reg, ol_next;
    logic                         od_reg, od_next;
    logic                         oo_reg, oo_next;
    logic                         slot_free;
    logic                         last_byte;

    // The read address follows the next index, so the read register always
    // holds the byte at the current index.
    assign rd_addr = RW'((cmd_next.bank ? LABEL_MAX : 0) + idx_next);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_addr < RW'(DEPTH))
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign slot_free = !ov_reg || out_ready;
    assign last_byte = (dnle_pkg::LEN_W'(idx_reg + 1'b1) == cmd_reg.len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dnle_pkg::B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
        od_reg  <= od_next;
        oo_reg  <= oo_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        oo_next    = oo_reg;
        cmd_pop    = 1'b0;
        rel.valid  = 1'b0;
        rel.bank   = cmd_reg.bank;
        case (state_reg)
            dnle_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    idx_next   = '0;
                    state_next = dnle_pkg::B_LEN;
                end
            end
            dnle_pkg::B_LEN:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    ob_next = dnle_pkg::CHAR_W'(cmd_reg.len);
                    ol_next = (cmd_reg.len == '0) && !cmd_reg.closing;
                    od_next = 1'b0;
                    oo_next = cmd_reg.ovf;
                    if (cmd_reg.len != '0)
                    begin
                        state_next = dnle_pkg::B_BYTE;
                    end
                    else if (cmd_reg.closing)
                    begin
                        state_next = dnle_pkg::B_TERM;
                    end
                    else
                    begin
                        rel.valid  = 1'b1;
                        state_next = dnle_pkg::B_IDLE;
                    end
                end
            end
            dnle_pkg::B_BYTE:
            begin
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    ob_next  = rd_data_reg;
                    ol_next  = last_byte && !cmd_reg.closing;
                    od_next  = 1'b0;
                    oo_next  = cmd_reg.ovf;
                    idx_next = idx_reg + 1'b1;
                    if (last_byte)
                    begin
                        if (cmd_reg.closing)
                        begin
                            state_next = dnle_pkg::B_TERM;
                        end
                        else
                        begin
                            rel.valid  = 1'b1;
                            state_next = dnle_pkg::B_IDLE;
                        end
                    end
                end
            end
            dnle_pkg::B_TERM:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = dnle_pkg::CH_END;
                    ol_next    = 1'b1;
                    od_next    = 1'b1;
                    oo_next    = cmd_reg.ovf;
                    rel.valid  = 1'b1;
                    state_next = dnle_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dnle_pkg::B_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;
    assign out_done  = od_reg;
    assign out_ovf   = oo_reg;

endmodule

`default_nettype wire

// ===== rtl/dnle_checker.sv =====
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks for the DNS name label encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire       m_axis_tlast,
    input wire [1:0] m_axis_tuser
);

    // The terminator always closes its run.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("name terminator without tlast");

    // The terminator byte is zero.
    a_done_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("name terminator is not a zero byte");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transfer");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/dns_wire_check_pkg.sv =====
// ----------------------------------------------------------------------------
// dns_wire_check_pkg
// Expected DNS wire bytes for the label encoder testbench, kept as a queue
// that is filled per accepted character and drained per output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

package dns_wire_check_pkg;

    localparam int unsigned LABEL_MAX = 62;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       run_end;
        logic       name_end;
        logic       trunc;
    } wire_item_t;

    class wire_form_scoreboard;

        logic [7:0]  label_bytes[LABEL_MAX];
        int unsigned label_len;
        bit          dropped;
        wire_item_t  wire_q[$];
        int unsigned errors;

        function new();
            label_len = 0;
            dropped   = 1'b0;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return wire_q.size();
        endfunction

        // Called once per accepted input transfer.
        function void take_char(logic [7:0] c);
            wire_item_t  w;
            int unsigned run_len;
            int unsigned k;
            if (c != dnle_pkg::CH_END && c != dnle_pkg::CH_DOT)
            begin
                if (label_len < LABEL_MAX)
                begin
                    label_bytes[label_len] = c;
                    label_len++;
                end
                else
                begin
                    dropped = 1'b1;
                end
                return;
            end
            // Length byte, label bytes, then the terminator when the name ends.
            run_len = label_len + ((c == dnle_pkg::CH_END) ? 2 : 1);
            for (k = 0; k < run_len; k++)
            begin
                if (k == 0)
                    w.wire_byte = 8'(label_len);
                else if (k <= label_len)
                    w.wire_byte = label_bytes[k - 1];
                else
                    w.wire_byte = 8'd0;
                w.name_end = (c == dnle_pkg::CH_END) && (k == label_len + 1);
                w.run_end  = (k == run_len - 1);
                w.trunc    = dropped;
                wire_q.push_back(w);
            end
            label_len = 0;
            dropped   = 1'b0;
        endfunction

        // Called once per accepted output transfer.
        function void check_byte(logic [7:0] data, logic last, logic [1:0] user);
            wire_item_t w;
            if (wire_q.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %0d", data);
                errors++;
                return;
            end
            w = wire_q.pop_front();
            if (data !== w.wire_byte)
            begin
                $error("out_byte: expected %0d, got %0d", w.wire_byte, data);
                errors++;
            end
            if (last !== w.run_end)
            begin
                $error("last_of_run: expected %0d, got %0d", w.run_end, last);
                errors++;
            end
            if (user[0] !== w.name_end)
            begin
                $error("name_done: expected %0d, got %0d", w.name_end, user[0]);
                errors++;
            end
            if (user[1] !== w.trunc)
            begin
                $error("label_overflow: expected %0d, got %0d", w.trunc, user[1]);
                errors++;
            end
        endfunction

    endclass

endpackage

`default_nettype wire

// ===== sim/tb_dns_name_label_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_dns_name_label_encoder
// Feeds host names character by character into the label encoder and checks
// every wire byte, its last_of_run, name_done and label_overflow flags
// against a predicted stream, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dns_name_label_encoder;

    localparam int unsigned RUN_LIMIT  = 200000;
    localparam int unsigned ITEM_COUNT = 280;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       m_axis_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    dns_wire_check_pkg::wire_form_scoreboard sb = new();

    int unsigned cycle_cnt = 0;
    int unsigned hold_req  = 0;
    bit          tx_nogap  = 1'b0;
    int unsigned tx_left   = 0;
    bit          tx_busy   = 1'b0;
    int unsigned items     = 0;

    dns_name_label_encoder #(
        .LABEL_MAX(dns_wire_check_pkg::LABEL_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Valid is only lowered when a gap follows, so a back-to-back transfer
    // keeps it high without a second assignment in the same step.
    task automatic send_char(input logic [7:0] c);
        int unsigned gap;
        if (tx_nogap)
        begin
            gap = 0;
        end
        else
        begin
            if (tx_left == 0)
            begin
                tx_left = $urandom_range(5, 40);
                tx_busy = ($urandom_range(0, 2) != 0);
            end
            tx_left--;
            gap = tx_busy ? $urandom_range(0, 10) : 0;
        end
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_char(c);
        items++;
    endtask

    task automatic send_label(input int unsigned len);
        logic [7:0] c;
        repeat (len)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == dnle_pkg::CH_DOT);
            send_char(c);
        end
    endtask

    // The last character has just been taken, so valid must drop before the
    // next edge or that character would be transferred a second time.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Output side: random ready gaps, calm stretches, and one long hold-off.
    initial
    begin
        int unsigned gap;
        int unsigned rx_left;
        bit          rx_busy;
        rx_left = 0;
        rx_busy = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != 0)
            begin
                gap      = hold_req;
                hold_req = 0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_left = $urandom_range(8, 40);
                    rx_busy = ($urandom_range(0, 2) != 0);
                end
                rx_left--;
                gap = rx_busy ? $urandom_range(0, 10) : 0;
            end
            repeat (gap)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    initial
    begin
        logic [7:0]  directed[14];
        int unsigned name_idx;
        int unsigned nlabels;
        int unsigned len;
        int unsigned l;

        // Empty name, leading dot, byte extremes, a double dot, a dot right
        // before the end of the name, and a plain short name.
        directed = '{dnle_pkg::CH_END,
                     dnle_pkg::CH_DOT, dnle_pkg::CH_END,
                     8'h01, 8'hFF, dnle_pkg::CH_DOT, dnle_pkg::CH_DOT, 8'h80, 8'h7F,
                     dnle_pkg::CH_DOT, dnle_pkg::CH_END,
                     8'h2D, 8'h2F, dnle_pkg::CH_END};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_char(directed[i]);
        wait_drained();

        // The receiver holds off while labels keep coming, so both buffer
        // banks fill and the input side has to stall.
        hold_req = 200;
        tx_nogap = 1'b1;
        repeat (6)
        begin
            send_label(4);
            send_char(dnle_pkg::CH_DOT);
        end
        send_char(dnle_pkg::CH_END);
        tx_nogap = 1'b0;

        name_idx = 0;
        while (items < ITEM_COUNT)
        begin
            nlabels = $urandom_range(1, 4);
            for (l = 0; l < nlabels; l++)
            begin
                if (name_idx == 0 && l == 0)
                    len = dns_wire_check_pkg::LABEL_MAX + 2;
                else if (name_idx == 1 && l == 0)
                    len = dns_wire_check_pkg::LABEL_MAX;
                else if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(dns_wire_check_pkg::LABEL_MAX - 2,
                                         dns_wire_check_pkg::LABEL_MAX + 4);
                else
                    len = $urandom_range(0, 8);
                send_label(len);
                // Now and then the separator is an arbitrary byte, which
                // breaks the name structure.
                if ($urandom_range(0, 9) == 0)
                    send_char(8'($urandom_range(0, 255)));
                else
                    send_char((l == nlabels - 1) ? dnle_pkg::CH_END : dnle_pkg::CH_DOT);
            end
            if (name_idx == 10)
                wait_drained();
            name_idx++;
        end
        send_char(dnle_pkg::CH_END);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge clk);

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
